/* src/pgl_pkg.sv */
// Shared types for the packed grayscale LED driver feed.
// Word layouts, request codes and the controller/datapath command and status groups.
// No dependencies.
`timescale 1ns / 1ps

package pgl_pkg;

  localparam int unsigned NumChannelsDef = 16;

  typedef enum logic [1:0] {
    REQ_SET_CH  = 2'd0,
    REQ_SET_ALL = 2'd1,
    REQ_UPDATE  = 2'd2,
    REQ_TICK    = 2'd3
  } req_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  channel;
    logic [11:0] value;
  } in_word_t;

  typedef struct packed {
    logic       blank_pulse;
    logic       latch_pulse;
    logic       extra_clock_pulse;
    logic       byte_valid;
    logic [7:0] serial_byte;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic cap;         // capture the input word
    logic set_upd;     // mark buffer for transfer
    logic start_tick;  // snapshot and clear latch / first flags
    logic fin_tick;    // stream done: latch next tick, update served
    logic load_empty;  // single result without data
    logic load_byte;   // result carrying the fetched byte
    logic wr_full;     // write the whole byte of a set-channel
    logic rd_rmw;      // fetch the shared nibble byte
    logic wr_rmw;      // write back the merged byte
    logic fill_start;  // reset fill counter and phase
    logic fill_wr;     // write one set-all byte
    logic rd_first;    // fetch byte 0 for streaming
    logic rd_next;     // fetch following byte
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic ch_ok;
    logic upd_pend;
    logic enable;
    logic out_free;
    logic cnt_last;
  } sts_t;

endpackage

/* src/packed_grayscale_led_driver_feed.sv */
// Top level of the packed 12-bit grayscale LED driver feed.
// Uses pgl_pkg, pgl_ctrl and pgl_datapath.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+--------------------
//   in      | input     | in_valid_i / in_stall_o | pgl_pkg::in_word_t
//   out     | output    | out_valid_o/out_stall_i | pgl_pkg::out_word_t
//   cfg     | input     | cfg_we_i                | cfg_wdata_i (enable)
//
// Set channel writes the full byte, then merges the nibble-shared byte; set all writes
// all B buffer bytes (B = (3*NumChannels+1)/2); a tick without pending update gives one
// empty result, with one it streams the B bytes, each one buffer read, one per cycle while out is free.
// Reset clears the buffer at once through per-byte valid bits; no clearing pass.
// A stalled output holds the word and blocks new input until it is taken.
`timescale 1ns / 1ps

module packed_grayscale_led_driver_feed #(
  parameter int unsigned NumChannels = pgl_pkg::NumChannelsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pgl_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pgl_pkg::out_word_t out_data_o,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i
);

  pgl_pkg::cmd_t cmd;
  pgl_pkg::sts_t sts;

  pgl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pgl_datapath #(
    .NumChannels (NumChannels)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

/* src/pgl_datapath.sv */
// Datapath: grayscale byte buffer with per-byte valid bits, counters, flags and output register.
// Uses pgl_pkg; driven by pgl_ctrl through cmd_t, reports through sts_t.
`timescale 1ns / 1ps

module pgl_datapath #(
  parameter int unsigned NumChannels = pgl_pkg::NumChannelsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pgl_pkg::in_word_t  in_data_i,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               out_stall_i,
  input  pgl_pkg::cmd_t      cmd_i,
  output pgl_pkg::sts_t      sts_o,
  output logic               out_valid_o,
  output pgl_pkg::out_word_t out_data_o
);

  localparam int unsigned GsBytes = (NumChannels * 3 + 1) / 2;
  localparam int unsigned AW      = $clog2(GsBytes);
  localparam int unsigned SW      = $clog2(NumChannels);

  logic [7:0]         mem_q [GsBytes];
  logic [GsBytes-1:0] vld_q;
  logic [7:0]         rdata_q;
  logic               rvld_q;

  logic [AW-1:0] cnt_q, cnt_d;
  logic [1:0]    ph_q, ph_d;
  logic [11:0]   val_q;
  logic          odd_q;
  logic [AW-1:0] rmw_addr_q;

  logic enable_q, upd_q, latch_q, first_q;
  logic tk_latch_q, tk_xclk_q;
  logic out_valid_q;
  pgl_pkg::out_word_t out_q;

  // set-channel address decode, straight from the input word
  logic [SW-1:0] slot;
  logic [AW-1:0] slot_ext, in_idx, in_idx1;
  logic          in_odd;
  assign slot     = SW'(NumChannels - 1) - SW'(in_data_i.channel);
  assign slot_ext = AW'(slot);
  assign in_idx   = slot_ext + (slot_ext >> 1);
  assign in_idx1  = in_idx + AW'(1);
  assign in_odd   = slot[0];

  logic [7:0] old_byte;
  assign old_byte = rvld_q ? rdata_q : 8'h00;

  logic [7:0] pat;
  always_comb begin
    case (ph_q)
      2'd0:    pat = val_q[11:4];
      2'd1:    pat = {val_q[3:0], val_q[11:8]};
      default: pat = val_q[7:0];
    endcase
  end

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (cmd_i.wr_full) begin
      wr_en   = 1'b1;
      wr_addr = in_odd ? in_idx1 : in_idx;
      wr_data = in_odd ? in_data_i.value[7:0] : in_data_i.value[11:4];
    end else if (cmd_i.wr_rmw) begin
      wr_en   = 1'b1;
      wr_addr = rmw_addr_q;
      wr_data = odd_q ? {old_byte[7:4], val_q[11:8]} : {val_q[3:0], old_byte[3:0]};
    end else if (cmd_i.fill_wr) begin
      wr_en   = 1'b1;
      wr_addr = cnt_q;
      wr_data = pat;
    end
  end

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  assign rd_en = cmd_i.rd_rmw | cmd_i.rd_first | cmd_i.rd_next;
  always_comb begin
    if (cmd_i.rd_rmw) begin
      rd_addr = in_odd ? in_idx : in_idx1;
    end else if (cmd_i.rd_first) begin
      rd_addr = '0;
    end else begin
      rd_addr = cnt_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
      rvld_q  <= vld_q[rd_addr];
    end
  end

  // a byte never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    ph_d  = ph_q;
    if (cmd_i.fill_start || cmd_i.rd_first) begin
      cnt_d = '0;
      ph_d  = 2'd0;
    end else if (cmd_i.fill_wr || cmd_i.rd_next) begin
      cnt_d = cnt_q + AW'(1);
      ph_d  = (ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ph_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      ph_q  <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      val_q      <= in_data_i.value;
      odd_q      <= in_odd;
      rmw_addr_q <= in_odd ? in_idx : in_idx1;
    end
    if (cmd_i.start_tick) begin
      tk_latch_q <= latch_q;
      tk_xclk_q  <= first_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      upd_q    <= 1'b0;
      latch_q  <= 1'b0;
      first_q  <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      if (cmd_i.set_upd) begin
        upd_q <= 1'b1;
      end
      if (cmd_i.start_tick) begin
        latch_q <= 1'b0;
        first_q <= 1'b0;
      end
      if (cmd_i.fin_tick) begin
        latch_q <= 1'b1;
        upd_q   <= 1'b0;
      end
    end
  end

  logic load;
  assign load = cmd_i.load_empty | cmd_i.load_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  logic first_byte;
  assign first_byte = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_empty) begin
      out_q.blank_pulse       <= 1'b1;
      out_q.latch_pulse       <= latch_q;
      out_q.extra_clock_pulse <= first_q;
      out_q.byte_valid        <= 1'b0;
      out_q.serial_byte       <= 8'h00;
      out_q.last              <= 1'b1;
    end else if (cmd_i.load_byte) begin
      out_q.blank_pulse       <= first_byte;
      out_q.latch_pulse       <= first_byte & tk_latch_q;
      out_q.extra_clock_pulse <= first_byte & tk_xclk_q;
      out_q.byte_valid        <= 1'b1;
      out_q.serial_byte       <= old_byte;
      out_q.last              <= sts_o.cnt_last;
    end
  end

  assign sts_o.req      = pgl_pkg::req_e'(in_data_i.req_type);
  assign sts_o.ch_ok    = 32'(in_data_i.channel) < NumChannels;
  assign sts_o.upd_pend = upd_q;
  assign sts_o.enable   = enable_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign sts_o.cnt_last = (cnt_q == AW'(GsBytes - 1));

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* src/pgl_ctrl.sv */
// Controller FSM: decodes accepted words and sequences buffer writes, fills and streams.
// Uses pgl_pkg; commands pgl_datapath through cmd_t.
`timescale 1ns / 1ps

module pgl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pgl_pkg::sts_t sts_i,
  output pgl_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RMW    = 4'b0010,
    ST_FILL   = 4'b0100,
    ST_STREAM = 4'b1000
  } state_e;

  state_e st_q, st_d;

  always_comb begin
    cmd_o      = '0;
    st_d       = st_q;
    in_stall_o = 1'b1;
    case (st_q)
      ST_IDLE: begin
        in_stall_o = !sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          case (sts_i.req)
            pgl_pkg::REQ_SET_CH: begin
              if (sts_i.ch_ok) begin
                // full byte now, nibble-shared byte fetched for merge
                cmd_o.cap     = 1'b1;
                cmd_o.wr_full = 1'b1;
                cmd_o.rd_rmw  = 1'b1;
                st_d          = ST_RMW;
              end
            end
            pgl_pkg::REQ_SET_ALL: begin
              cmd_o.cap        = 1'b1;
              cmd_o.fill_start = 1'b1;
              st_d             = ST_FILL;
            end
            pgl_pkg::REQ_UPDATE: begin
              cmd_o.set_upd = 1'b1;
            end
            pgl_pkg::REQ_TICK: begin
              if (sts_i.enable) begin
                cmd_o.start_tick = 1'b1;
                if (sts_i.upd_pend) begin
                  cmd_o.rd_first = 1'b1;
                  st_d           = ST_STREAM;
                end else begin
                  cmd_o.load_empty = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_RMW: begin
        cmd_o.wr_rmw = 1'b1;
        st_d         = ST_IDLE;
      end
      ST_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (sts_i.cnt_last) begin
          st_d = ST_IDLE;
        end
      end
      ST_STREAM: begin
        // fetched byte waits in the read register until the output frees up
        if (sts_i.out_free) begin
          cmd_o.load_byte = 1'b1;
          if (sts_i.cnt_last) begin
            cmd_o.fin_tick = 1'b1;
            st_d           = ST_IDLE;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

/* verif/pgl_feed_checker.sv */
// Watches the word, result and enable ports of packed_grayscale_led_driver_feed.
// It tracks the grayscale buffer and the tick flags, and compares every result word.
// Depends on pgl_pkg.
`timescale 1ns / 1ps

module pgl_feed_checker #(
  parameter int unsigned NumChannels = pgl_pkg::NumChannelsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  pgl_pkg::in_word_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  pgl_pkg::out_word_t out_data_i,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  output int unsigned        err_cnt_o,
  output int unsigned        owed_cnt_o
);

  localparam int unsigned GsBytes = (3 * NumChannels + 1) / 2;

  logic [7:0]         gs_buf [GsBytes];
  logic               upd_pend;
  logic               latch_pend;
  logic               first_tick;
  logic               enabled;
  pgl_pkg::out_word_t owed_q [$];
  pgl_pkg::out_word_t due;
  int unsigned        n_err;

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      n_err++;
    end
  endtask

  task automatic compare_word(input pgl_pkg::out_word_t want, input pgl_pkg::out_word_t got);
    check_field("blank_pulse", want.blank_pulse, got.blank_pulse);
    check_field("latch_pulse", want.latch_pulse, got.latch_pulse);
    check_field("extra_clock_pulse", want.extra_clock_pulse, got.extra_clock_pulse);
    check_field("byte_valid", want.byte_valid, got.byte_valid);
    check_field("serial_byte", want.serial_byte, got.serial_byte);
    check_field("last", want.last, got.last);
  endtask

  // Update buffer and flags for one accepted word, queue the results it owes.
  task automatic apply_word(input pgl_pkg::in_word_t w);
    int unsigned        slot;
    int unsigned        idx;
    logic [7:0]         pat [3];
    pgl_pkg::out_word_t r;
    case (pgl_pkg::req_e'(w.req_type))
      pgl_pkg::REQ_SET_CH: begin
        if (w.channel < NumChannels) begin
          // channels are stored reversed, two per three bytes
          slot = NumChannels - 1 - w.channel;
          idx  = slot * 3 / 2;
          if (idx + 1 < GsBytes) begin
            if (slot % 2 == 0) begin
              gs_buf[idx]   = w.value[11:4];
              gs_buf[idx+1] = {w.value[3:0], gs_buf[idx+1][3:0]};
            end else begin
              gs_buf[idx]   = {gs_buf[idx][7:4], w.value[11:8]};
              gs_buf[idx+1] = w.value[7:0];
            end
          end
        end
      end
      pgl_pkg::REQ_SET_ALL: begin
        pat[0] = w.value[11:4];
        pat[1] = {w.value[3:0], w.value[11:8]};
        pat[2] = w.value[7:0];
        for (int i = 0; i < GsBytes; i++) gs_buf[i] = pat[i % 3];
      end
      pgl_pkg::REQ_UPDATE: upd_pend = 1'b1;
      pgl_pkg::REQ_TICK: begin
        if (enabled) begin
          r                   = '0;
          r.blank_pulse       = 1'b1;
          r.latch_pulse       = latch_pend;
          r.extra_clock_pulse = first_tick;
          latch_pend          = 1'b0;
          first_tick          = 1'b0;
          if (!upd_pend) begin
            r.last = 1'b1;
            owed_q.push_back(r);
          end else begin
            for (int i = 0; i < GsBytes; i++) begin
              if (i > 0) begin
                r.blank_pulse       = 1'b0;
                r.latch_pulse       = 1'b0;
                r.extra_clock_pulse = 1'b0;
              end
              r.byte_valid  = 1'b1;
              r.serial_byte = gs_buf[i];
              r.last        = (i == GsBytes - 1);
              owed_q.push_back(r);
            end
            latch_pend = 1'b1;
            upd_pend   = 1'b0;
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < GsBytes; i++) gs_buf[i] = '0;
      upd_pend   = 1'b0;
      latch_pend = 1'b0;
      first_tick = 1'b1;
      enabled    = 1'b0;
      owed_q.delete();
      n_err      = 0;
      err_cnt_o  <= 0;
      owed_cnt_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected word: expected none, got %p", $time, out_data_i);
          n_err++;
        end else begin
          due = owed_q.pop_front();
          compare_word(due, out_data_i);
        end
      end
      if (cfg_we_i) enabled = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) apply_word(in_data_i);
      err_cnt_o  <= n_err;
      owed_cnt_o <= owed_q.size();
    end
  end

endmodule

/* verif/tb_top.sv */
// Testbench top for packed_grayscale_led_driver_feed: clock, reset, word stimulus,
// output back-pressure, enable writes, watchdog and verdict.
// Depends on pgl_pkg, pgl_feed_checker and the block itself.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned DrainCycles = 40;
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned HoldCycles  = 400;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall;
  pgl_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_stall;
  pgl_pkg::out_word_t out_data;
  logic               cfg_we;
  logic               cfg_wdata;
  int unsigned        err_cnt;
  int unsigned        owed_cnt;

  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  logic        hold_req;
  logic        en_now;
  int unsigned quiet_cycles;

  packed_grayscale_led_driver_feed i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  pgl_feed_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_data_i (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .err_cnt_o  (err_cnt),
    .owed_cnt_o (owed_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stall, plus one long hold-off when requested.
  initial begin : rx_side
    int unsigned hold_left;
    logic        hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("** packed_grayscale_led_driver_feed: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one word, holding it until taken.
  task automatic push_word(input pgl_pkg::in_word_t w);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic feed(input pgl_pkg::req_e req, input logic [3:0] ch,
                      input logic [11:0] val);
    pgl_pkg::in_word_t w;
    w.req_type = req;
    w.channel  = ch;
    w.value    = val;
    push_word(w);
  endtask

  // Wait until every owed result is out, then let any set-all finish.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (owed_cnt != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_enable(input logic v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    en_now = v;
  endtask

  function automatic pgl_pkg::in_word_t rand_word();
    pgl_pkg::in_word_t w;
    int unsigned       pick;
    pick = $urandom_range(99);
    if (pick < 35)      w.req_type = pgl_pkg::REQ_SET_CH;
    else if (pick < 45) w.req_type = pgl_pkg::REQ_SET_ALL;
    else if (pick < 70) w.req_type = pgl_pkg::REQ_UPDATE;
    else                w.req_type = pgl_pkg::REQ_TICK;
    w.channel = 4'($urandom_range(15));
    case ($urandom_range(7))
      0:       w.value = 12'h000;
      1:       w.value = 12'hfff;
      default: w.value = 12'($urandom_range(4095));
    endcase
    return w;
  endfunction

  // Disabled ticks do nothing and are not counted.
  task automatic run_random(input int unsigned n);
    int unsigned       done;
    pgl_pkg::in_word_t w;
    done = 0;
    while (done < n) begin
      w = rand_word();
      push_word(w);
      if (!(pgl_pkg::req_e'(w.req_type) == pgl_pkg::REQ_TICK && !en_now)) done++;
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = 1'b0;
    hold_req     = 1'b0;
    en_now       = 1'b0;
    in_idle_pct  = 0;
    out_idle_pct = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: disabled tick, first tick extra clock, cleared buffer, latch,
    // packing of both slot parities at the ends, set-all pattern, double request
    feed(pgl_pkg::REQ_TICK, 4'd0, 12'h000);
    write_enable(1'b1);
    feed(pgl_pkg::REQ_TICK, 4'd0, 12'h000);
    feed(pgl_pkg::REQ_UPDATE, 4'd0, 12'h000);
    feed(pgl_pkg::REQ_TICK, 4'd0, 12'h000);
    feed(pgl_pkg::REQ_TICK, 4'd0, 12'h000);
    feed(pgl_pkg::REQ_SET_ALL, 4'd0, 12'h5a3);
    feed(pgl_pkg::REQ_SET_CH, 4'd0, 12'hfff);
    feed(pgl_pkg::REQ_SET_CH, 4'd15, 12'h000);
    feed(pgl_pkg::REQ_SET_CH, 4'd7, 12'h001);
    feed(pgl_pkg::REQ_SET_CH, 4'd8, 12'h800);
    feed(pgl_pkg::REQ_UPDATE, 4'd15, 12'hfff);
    feed(pgl_pkg::REQ_TICK, 4'd15, 12'hfff);
    feed(pgl_pkg::REQ_TICK, 4'd0, 12'h000);
    feed(pgl_pkg::REQ_SET_ALL, 4'd15, 12'h000);
    feed(pgl_pkg::REQ_UPDATE, 4'd0, 12'h000);
    feed(pgl_pkg::REQ_UPDATE, 4'd0, 12'h000);
    feed(pgl_pkg::REQ_TICK, 4'd0, 12'h000);
    feed(pgl_pkg::REQ_SET_ALL, 4'd0, 12'hfff);
    feed(pgl_pkg::REQ_UPDATE, 4'd0, 12'h000);
    write_enable(1'b0);
    feed(pgl_pkg::REQ_TICK, 4'd0, 12'h000);   // pending update must survive this
    write_enable(1'b1);
    feed(pgl_pkg::REQ_TICK, 4'd0, 12'h000);

    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin
          in_idle_pct  = 15;
          out_idle_pct = 73;
        end
        1: begin
          in_idle_pct  = 73;
          out_idle_pct = 15;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      write_enable(1'b0);
      run_random(15);
      write_enable(1'b1);
      if (m == 2) hold_req <= 1'b1;   // fill the block behind a long receiver hold
      run_random(130);
    end

    drain();
    if (err_cnt == 0 && owed_cnt == 0) begin
      $display("** packed_grayscale_led_driver_feed: PASSED **");
    end else begin
      $display("** packed_grayscale_led_driver_feed: FAILED **");
    end
    $finish;
  end

endmodule
